// File: rtl/core/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // Default sizes
    localparam int MPQ_DEPTH         = 16;
    localparam int MPQ_KEY_WIDTH     = 16;
    localparam int MPQ_PAYLOAD_WIDTH = 32;

    // Operation codes on i_kind
    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CLR = 2'd2
    } t_kind;

    // Result status codes on o_status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast shift control for the cell chain
    typedef struct packed {
        logic enq;  // insert: cells above the slot shift right
        logic deq;  // remove head: every cell shifts left
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/core/min_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded min priority queue built as a sorted chain of cells.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. i_kind selects enqueue (store i_key/i_payload), dequeue
// (remove the smallest key; ties go to the oldest entry) or clear.
// busy is held low: the queue takes one transaction every cycle.
//
// Result channel: exactly one result per transaction, on the o_ ports for
// one cycle with o_strobe high, in the cycle after the command. Throughput
// is one transaction per cycle, set by the single register stage of the
// cell chain: each cell decides shift-left, shift-right, load-new or hold
// from one broadcast compare against the incoming key.
// The receiver cannot stall; a result not taken in its cycle is gone.
//
// o_status reports ok, enqueue refused (full) or dequeue on empty.
// o_out_key/o_out_payload are zero unless a dequeue succeeded.
// o_occupancy is the entry count after the transaction.
//
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared since only the count qualifies them.

module min_priority_queue_top
    import mpq_pkg::*;
#(
    parameter int DEPTH         = MPQ_DEPTH,
    parameter int KEY_WIDTH     = MPQ_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = MPQ_PAYLOAD_WIDTH,
    localparam int CW           = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_kind,
    input  wire logic [KEY_WIDTH-1:0]     i_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_payload,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [KEY_WIDTH-1:0]          o_out_key,
    output logic [PAYLOAD_WIDTH-1:0]      o_out_payload,
    output logic [CW-1:0]                 o_occupancy
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Cell chain wiring; cell 0 holds the current minimum
    logic [KEY_WIDTH-1:0]     w_key  [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_pay  [DEPTH];
    logic                     w_keep [DEPTH];
    t_cell_ctl                w_ctl;

    logic                     w_accept;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_strobe;
    t_status                  r_status;
    t_status                  n_status;
    logic [KEY_WIDTH-1:0]     r_out_key;
    logic [KEY_WIDTH-1:0]     n_out_key;
    logic [PAYLOAD_WIDTH-1:0] r_out_pay;
    logic [PAYLOAD_WIDTH-1:0] n_out_pay;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Command decode: count update, cell control and result fields
    always_comb begin
        w_ctl     = '0;
        n_count   = r_count;
        n_status  = ST_OK;
        n_out_key = '0;
        n_out_pay = '0;
        if (w_accept) begin
            case (t_kind'(i_kind))
                KIND_ENQ: begin
                    if (r_count == DEPTH_C) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.enq = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                KIND_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.deq = 1'b1;
                        n_out_key = w_key[0];
                        n_out_pay = w_pay[0];
                        n_count   = r_count - CW'(1);
                    end
                end
                KIND_CLR: begin
                    n_count = '0;
                end
                default: begin
                    // unused code: no change, status ok
                end
            endcase
        end
    end

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                     w_lkeep;
            logic [KEY_WIDTH-1:0]     w_lkey;
            logic [PAYLOAD_WIDTH-1:0] w_lpay;
            logic [KEY_WIDTH-1:0]     w_rkey;
            logic [PAYLOAD_WIDTH-1:0] w_rpay;

            if (gi == 0) begin : g_head
                // nothing to the left: head loads the new entry unless it keeps
                assign w_lkeep = 1'b1;
                assign w_lkey  = '0;
                assign w_lpay  = '0;
            end else begin : g_mid
                assign w_lkeep = w_keep[gi-1];
                assign w_lkey  = w_key[gi-1];
                assign w_lpay  = w_pay[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_rkey = '0;
                assign w_rpay = '0;
            end else begin : g_body
                assign w_rkey = w_key[gi+1];
                assign w_rpay = w_pay[gi+1];
            end

            mpq_cell #(
                .IDX           (gi),
                .COUNT_WIDTH   (CW),
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk           (i_clk),
                .i_ctl           (w_ctl),
                .i_count         (r_count),
                .i_new_key       (i_key),
                .i_new_payload   (i_payload),
                .i_left_keep     (w_lkeep),
                .i_left_key      (w_lkey),
                .i_left_payload  (w_lpay),
                .i_right_key     (w_rkey),
                .i_right_payload (w_rpay),
                .o_keep          (w_keep[gi]),
                .o_key           (w_key[gi]),
                .o_payload       (w_pay[gi])
            );
        end
    endgenerate

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    // Result payload, qualified by r_strobe
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_out_key <= n_out_key;
        r_out_pay <= n_out_pay;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_pay;
    assign o_occupancy   = r_count;

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("accepted transaction gave no result");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with entries held");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_occupancy == DEPTH_C))
        else $error("full status below depth");

    generate
        for (genvar ga = 0; ga < DEPTH - 1; ga++) begin : g_chk_sorted
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_count > CW'(ga + 1)) |-> (w_key[ga] <= w_key[ga+1]))
                else $error("cell chain out of key order");
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/core/mpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell
    import mpq_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int COUNT_WIDTH   = 5,
    parameter int KEY_WIDTH     = MPQ_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = MPQ_PAYLOAD_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [COUNT_WIDTH-1:0]   i_count,
    input  wire logic [KEY_WIDTH-1:0]     i_new_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_new_payload,
    input  wire logic                     i_left_keep,
    input  wire logic [KEY_WIDTH-1:0]     i_left_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_left_payload,
    input  wire logic [KEY_WIDTH-1:0]     i_right_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] i_right_payload,
    output logic                          o_keep,
    output logic [KEY_WIDTH-1:0]          o_key,
    output logic [PAYLOAD_WIDTH-1:0]      o_payload
);

    localparam logic [COUNT_WIDTH-1:0] IDX_C = COUNT_WIDTH'(IDX);

    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [KEY_WIDTH-1:0]     n_key;
    logic [PAYLOAD_WIDTH-1:0] n_payload;
    logic                     w_valid;

    // Equal keys stay put, so a new entry lands after older equal ones.
    assign w_valid = IDX_C < i_count;
    assign o_keep  = w_valid && (r_key <= i_new_key);

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        if (i_ctl.enq) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_key     = i_new_key;
                    n_payload = i_new_payload;
                end else begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end
            end
        end else if (i_ctl.deq) begin
            n_key     = i_right_key;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

`default_nettype wire
